### src/pwfw_pkg.sv
`timescale 1ns / 1ps

package pwfw_pkg;

   // Field and register widths.
   localparam int DATA_WIDTH      = 16;
   localparam int GAIN_WIDTH      = 16;
   localparam int GAIN_FRAC_BITS  = 8;
   localparam int LIMIT_WIDTH     = 15;
   localparam int WRAP_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   // Internal arithmetic widths.
   localparam int DIFF_WIDTH  = DATA_WIDTH + 1;           // setpoint minus something
   localparam int ERR_WIDTH   = 24;                       // saturated error
   localparam int ACC_WIDTH   = 24;                       // integral accumulator, Q.8
   localparam int MUL_B_WIDTH = ERR_WIDTH + 1;            // widest multiplicand
   localparam int PROD_WIDTH  = GAIN_WIDTH + MUL_B_WIDTH;
   localparam int FFT_WIDTH   = GAIN_WIDTH + DIFF_WIDTH;  // feedforward product
   localparam int INT_WIDTH   = PROD_WIDTH + 1;           // accumulator plus product
   localparam int SUM_WIDTH   = 44;                       // P + I + D + feedforward

   // Register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_LOOP_MODE      = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_P         = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_I         = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_D         = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GAIN_FF        = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_INTEGRAL_LIMIT = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_OUTPUT_LIMIT   = 3'd6;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WRAP_RANGE     = 3'd7;

   localparam logic MODE_ANGLE = 1'b0;
   localparam logic MODE_SPEED = 1'b1;

   localparam logic [LIMIT_WIDTH-1:0] OUTPUT_LIMIT_RESET = 15'd32767;
   localparam logic [WRAP_WIDTH-1:0]  WRAP_RANGE_RESET   = 16'd8192;

   // Multiplier operand selection.
   localparam logic [1:0] MUL_FF = 2'd0;
   localparam logic [1:0] MUL_I  = 2'd1;
   localparam logic [1:0] MUL_P  = 2'd2;
   localparam logic [1:0] MUL_D  = 2'd3;

   // Accumulator operations.
   localparam logic [1:0] SUM_HOLD   = 2'd0;
   localparam logic [1:0] SUM_INIT   = 2'd1;
   localparam logic [1:0] SUM_ADD_PI = 2'd2;
   localparam logic [1:0] SUM_ADD_D  = 2'd3;

   typedef struct packed {
      logic                   loop_mode;
      logic [GAIN_WIDTH-1:0]  gain_p;
      logic [GAIN_WIDTH-1:0]  gain_i;
      logic [GAIN_WIDTH-1:0]  gain_d;
      logic [GAIN_WIDTH-1:0]  gain_ff;
      logic [LIMIT_WIDTH-1:0] integral_limit;
      logic [LIMIT_WIDTH-1:0] output_limit;
      logic [WRAP_WIDTH-1:0]  wrap_range;
   } cfg_type;

   typedef struct packed {
      logic       capture;
      logic [1:0] mul_sel;
      logic       err_load;
      logic       int_load;
      logic [1:0] sum_op;
      logic       out_load;
   } cmd_type;

endpackage

### src/pid_with_feedforward_and_wrap.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload                     Direction
// req       req_valid/req_ready  req_setpoint, req_measurement  in
// rsp       rsp_valid/rsp_ready  rsp_drive                    out
// csr       csr_valid/csr_ready  csr_index, csr_wdata         in
//
// A request occupies the block from the idle state in which it is accepted through seven
// sequencer steps, four of which share the one 16 x 25 signed multiplier (feedforward,
// integral, proportional and derivative products in turn). The result is offered once the
// final step loads the drive register, and the block takes no new request until it has
// returned to idle.
// Reset is synchronous and active high; it restores the register defaults and clears the
// integral, the last error and the last setpoint.
// A held result stalls only the final step; the next request may be accepted while the
// previous result is still waiting. Register writes are always accepted.

module pid_with_feedforward_and_wrap (
   input  logic                                    clock,
   input  logic                                    reset,

   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [pwfw_pkg::DATA_WIDTH-1:0]  req_setpoint,
   input  logic signed [pwfw_pkg::DATA_WIDTH-1:0]  req_measurement,

   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [pwfw_pkg::DATA_WIDTH-1:0]  rsp_drive,

   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [pwfw_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [pwfw_pkg::CSR_DATA_WIDTH-1:0]     csr_wdata
);

   pwfw_pkg::cfg_type cfg;
   pwfw_pkg::cmd_type cmd;

   // The register file has no busy state, so it never stalls a write.
   assign csr_ready = 1'b1;

   pwfw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The sequencer walks each request through the shared multiplier and owns the
   // result valid flag; the datapath holds all arithmetic and the loop state.
   pwfw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pwfw_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .req_setpoint    (req_setpoint),
      .req_measurement (req_measurement),
      .rsp_drive       (rsp_drive)
   );

endmodule

### src/pwfw_csr.sv
`timescale 1ns / 1ps

module pwfw_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write,
   input  logic [pwfw_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [pwfw_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata,
   output pwfw_pkg::cfg_type                      cfg
);

   pwfw_pkg::cfg_type cfg_ff;
   pwfw_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            pwfw_pkg::REG_LOOP_MODE:      cfg_in.loop_mode      = csr_wdata[0];
            pwfw_pkg::REG_GAIN_P:         cfg_in.gain_p         = csr_wdata;
            pwfw_pkg::REG_GAIN_I:         cfg_in.gain_i         = csr_wdata;
            pwfw_pkg::REG_GAIN_D:         cfg_in.gain_d         = csr_wdata;
            pwfw_pkg::REG_GAIN_FF:        cfg_in.gain_ff        = csr_wdata;
            pwfw_pkg::REG_INTEGRAL_LIMIT:
               cfg_in.integral_limit = csr_wdata[pwfw_pkg::LIMIT_WIDTH-1:0];
            pwfw_pkg::REG_OUTPUT_LIMIT:
               cfg_in.output_limit = csr_wdata[pwfw_pkg::LIMIT_WIDTH-1:0];
            pwfw_pkg::REG_WRAP_RANGE:     cfg_in.wrap_range     = csr_wdata;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   // Reset value: angle mode, all gains and the integral limit zero, output limit and
   // wrap span at their defaults.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= {pwfw_pkg::MODE_ANGLE,
                    {(4 * pwfw_pkg::GAIN_WIDTH){1'b0}},
                    {pwfw_pkg::LIMIT_WIDTH{1'b0}},
                    pwfw_pkg::OUTPUT_LIMIT_RESET,
                    pwfw_pkg::WRAP_RANGE_RESET};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### src/pwfw_dp.sv
`timescale 1ns / 1ps

module pwfw_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pwfw_pkg::cfg_type                     cfg,
   input  pwfw_pkg::cmd_type                     cmd,
   input  logic signed [pwfw_pkg::DATA_WIDTH-1:0] req_setpoint,
   input  logic signed [pwfw_pkg::DATA_WIDTH-1:0] req_measurement,
   output logic signed [pwfw_pkg::DATA_WIDTH-1:0] rsp_drive
);

   localparam int DW  = pwfw_pkg::DATA_WIDTH;
   localparam int GW  = pwfw_pkg::GAIN_WIDTH;
   localparam int FB  = pwfw_pkg::GAIN_FRAC_BITS;
   localparam int LW  = pwfw_pkg::LIMIT_WIDTH;
   localparam int WW  = pwfw_pkg::WRAP_WIDTH;
   localparam int DFW = pwfw_pkg::DIFF_WIDTH;
   localparam int EW  = pwfw_pkg::ERR_WIDTH;
   localparam int AW  = pwfw_pkg::ACC_WIDTH;
   localparam int BW  = pwfw_pkg::MUL_B_WIDTH;
   localparam int PW  = pwfw_pkg::PROD_WIDTH;
   localparam int FW  = pwfw_pkg::FFT_WIDTH;
   localparam int IW  = pwfw_pkg::INT_WIDTH;
   localparam int SW  = pwfw_pkg::SUM_WIDTH;
   localparam int TW  = DFW + 2;       // room for twice the error against the wrap span
   localparam int VW  = FW + 1;        // speed-mode error before saturation

   logic signed [DW-1:0] sp_ff, meas_ff, last_sp_ff;
   logic signed [EW-1:0] err_ff, last_err_ff, err_in;
   logic signed [AW-1:0] acc_ff, acc_in;
   logic signed [PW-1:0] prod_ff, mul_p;
   logic signed [FW-1:0] fft_ff;
   logic signed [SW-1:0] sum_ff, sum_in;
   logic signed [DW-1:0] drive_ff, drive_in;

   logic signed [DFW-1:0] dsp, diff;
   logic signed [BW-1:0]  derr, mul_b;
   logic signed [GW-1:0]  mul_a;

   logic signed [TW-1:0]  twice, wrap_s, diff_t, fold;
   logic signed [FW-1:0]  fft_now, fft_shr;
   logic signed [VW-1:0]  speed_raw;
   logic                  speed_fits;

   logic signed [IW-1:0]  int_raw, ilim;
   logic signed [SW-1:0]  sum_shr, olim;

   // Differences feeding the multiplier.
   assign dsp  = DFW'(sp_ff) - DFW'(last_sp_ff);
   assign diff = DFW'(sp_ff) - DFW'(meas_ff);
   assign derr = BW'(err_ff) - BW'(last_err_ff);

   always_comb begin
      case (cmd.mul_sel)
         pwfw_pkg::MUL_FF: begin
            mul_a = $signed(cfg.gain_ff);
            mul_b = BW'(dsp);
         end
         pwfw_pkg::MUL_I: begin
            mul_a = $signed(cfg.gain_i);
            mul_b = BW'(err_ff);
         end
         pwfw_pkg::MUL_P: begin
            mul_a = $signed(cfg.gain_p);
            mul_b = BW'(err_ff);
         end
         pwfw_pkg::MUL_D: begin
            mul_a = $signed(cfg.gain_d);
            mul_b = derr;
         end
         default: begin
            mul_a = $signed(cfg.gain_ff);
            mul_b = BW'(dsp);
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;

   // Error: angle mode folds by one wrap span, speed mode adds the scaled feedforward.
   assign diff_t = TW'(diff);
   assign twice  = diff_t <<< 1;
   assign wrap_s = $signed({{(TW-WW){1'b0}}, cfg.wrap_range});

   always_comb begin
      if (twice > wrap_s) begin
         fold = diff_t - wrap_s;
      end else if (twice < -wrap_s) begin
         fold = diff_t + wrap_s;
      end else begin
         fold = diff_t;
      end
   end

   assign fft_now    = prod_ff[FW-1:0];
   assign fft_shr    = fft_now >>> FB;
   assign speed_raw  = VW'(fft_shr) + VW'(diff);
   assign speed_fits = (speed_raw[VW-1:EW-1] == '0) || (speed_raw[VW-1:EW-1] == '1);

   always_comb begin
      if (cfg.loop_mode == pwfw_pkg::MODE_ANGLE) begin
         err_in = EW'(fold);
      end else if (speed_fits) begin
         err_in = speed_raw[EW-1:0];
      end else if (speed_raw[VW-1]) begin
         err_in = {1'b1, {(EW-1){1'b0}}};
      end else begin
         err_in = {1'b0, {(EW-1){1'b1}}};
      end
   end

   // Integral with symmetric clamp at integral_limit in output units.
   assign int_raw = IW'(acc_ff) + IW'(prod_ff);
   assign ilim    = $signed({{(IW-LW-FB){1'b0}}, cfg.integral_limit, {FB{1'b0}}});

   always_comb begin
      if (int_raw > ilim) begin
         acc_in = ilim[AW-1:0];
      end else if (int_raw < -ilim) begin
         acc_in = AW'(-ilim);
      end else begin
         acc_in = int_raw[AW-1:0];
      end
   end

   always_comb begin
      case (cmd.sum_op)
         pwfw_pkg::SUM_HOLD:   sum_in = sum_ff;
         pwfw_pkg::SUM_INIT:
            sum_in = (cfg.loop_mode == pwfw_pkg::MODE_ANGLE) ? SW'(fft_ff) : '0;
         pwfw_pkg::SUM_ADD_PI: sum_in = sum_ff + SW'(acc_ff) + SW'(prod_ff);
         pwfw_pkg::SUM_ADD_D:  sum_in = sum_ff + SW'(prod_ff);
         default:              sum_in = sum_ff;
      endcase
   end

   // Drive: drop the fraction (toward minus infinity) and clamp.
   assign sum_shr = sum_ff >>> FB;
   assign olim    = $signed({{(SW-LW){1'b0}}, cfg.output_limit});

   always_comb begin
      if (sum_shr > olim) begin
         drive_in = olim[DW-1:0];
      end else if (sum_shr < -olim) begin
         drive_in = DW'(-olim);
      end else begin
         drive_in = sum_shr[DW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_sp_ff  <= '0;
         last_err_ff <= '0;
         acc_ff      <= '0;
      end else begin
         if (cmd.int_load) begin
            acc_ff <= acc_in;
         end
         if (cmd.out_load) begin
            last_sp_ff  <= sp_ff;
            last_err_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
      sum_ff  <= sum_in;
      if (cmd.capture) begin
         sp_ff   <= req_setpoint;
         meas_ff <= req_measurement;
      end
      if (cmd.err_load) begin
         err_ff <= err_in;
         fft_ff <= fft_now;
      end
      if (cmd.out_load) begin
         drive_ff <= drive_in;
      end
   end

   assign rsp_drive = drive_ff;

endmodule

### src/pwfw_ctrl.sv
`timescale 1ns / 1ps

module pwfw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output pwfw_pkg::cmd_type cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_FF    = 3'd1;
   localparam logic [2:0] ST_ERR   = 3'd2;
   localparam logic [2:0] ST_IMUL  = 3'd3;
   localparam logic [2:0] ST_INT   = 3'd4;
   localparam logic [2:0] ST_PTERM = 3'd5;
   localparam logic [2:0] ST_DTERM = 3'd6;
   localparam logic [2:0] ST_OUT   = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.mul_sel  = pwfw_pkg::MUL_FF;
      cmd.sum_op   = pwfw_pkg::SUM_HOLD;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_FF;
            end
         end
         ST_FF: begin
            cmd.mul_sel = pwfw_pkg::MUL_FF;
            state_in    = ST_ERR;
         end
         ST_ERR: begin
            cmd.err_load = 1'b1;
            state_in     = ST_IMUL;
         end
         ST_IMUL: begin
            cmd.mul_sel = pwfw_pkg::MUL_I;
            state_in    = ST_INT;
         end
         ST_INT: begin
            cmd.int_load = 1'b1;
            cmd.sum_op   = pwfw_pkg::SUM_INIT;
            cmd.mul_sel  = pwfw_pkg::MUL_P;
            state_in     = ST_PTERM;
         end
         ST_PTERM: begin
            cmd.sum_op  = pwfw_pkg::SUM_ADD_PI;
            cmd.mul_sel = pwfw_pkg::MUL_D;
            state_in    = ST_DTERM;
         end
         ST_DTERM: begin
            cmd.sum_op = pwfw_pkg::SUM_ADD_D;
            state_in   = ST_OUT;
         end
         ST_OUT: begin
            cmd.out_load = out_free;
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A new drive value never overwrites one that is still waiting.
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("drive register loaded while a result is still pending");

   // An accepted request always starts the feedforward multiply next.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_FF))
      else $error("accepted request did not start the sequence");

   // A result appears only from the final step of a request.
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.out_load))
      else $error("result valid raised without a drive load");

   // The integral accumulator moves only in the middle of a request.
   a_int_in_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.int_load |-> ($past(state_ff) == ST_IMUL))
      else $error("integral update out of sequence");

endmodule
